>>> hdl/btmll_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the burst trimmed-mean light level block.
package btmll_pkg;

   // Full-scale brightness in percent with eight fraction bits.
   localparam int PCT_W = 15;
   localparam logic [PCT_W-1:0] PCT_FULL_Q8 = 15'd25600;

   // Fill status of the burst queue between the sorter and the arithmetic part.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> hdl/burst_trimmed_mean_light_level_top.sv
`timescale 1ns / 1ps
// Top level of the burst trimmed-mean light level block.
//
// Requests enter through a queue-style port: a sample is taken at a clock edge
// where req_push is high and req_full is low. Each sample is inserted at once
// into a sorting cell chain, so samples may arrive on every cycle while req_full
// is low. When the chain holds a full burst of BURST_SIZE samples, the sorted
// burst moves into a two-entry queue and the chain starts on the next burst.
// The arithmetic back end takes one burst at a time: it sums the kept samples,
// one per cycle, then divides for the rounded mean and again for the brightness
// percentage, each division a multiplication by a scaled reciprocal with a
// registered quotient. The sorter collects the next burst while the back end
// works on the last one; with the defaults the back end needs longer per burst
// than the sorter does, so a sender that never pauses eventually sees req_full.
// A result appears on rsp_raw_mean and rsp_percent_q8 while rsp_empty is low and
// is taken at an edge where rsp_pop is high. If the receiver stalls, one result
// waits in the output register, the back end finishes the next burst and then
// holds, and req_full rises once both queue entries are occupied.
// A synchronous reset empties the queue and the output register and restarts
// the burst count.
module burst_trimmed_mean_light_level_top #(
   parameter int BURST_SIZE  = 9,
   parameter int TRIM        = 2,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [SAMPLE_BITS-1:0]      req_sample,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [SAMPLE_BITS-1:0]      rsp_raw_mean,
   output logic [btmll_pkg::PCT_W-1:0] rsp_percent_q8
);

   localparam int ENTRY_W = BURST_SIZE * SAMPLE_BITS;

   btmll_pkg::q_status_type q_status;
   logic                    accept;
   logic                    burst_push;
   logic [ENTRY_W-1:0]      burst_data;
   logic [ENTRY_W-1:0]      q_data;
   logic                    q_pop;

   // Stall requests whenever the burst queue is full, so a completed burst
   // always finds room.
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   btmll_sort #(
      .BURST_SIZE (BURST_SIZE),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_sort (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .sample    (req_sample),
      .burst_push(burst_push),
      .burst_data(burst_data)
   );

   btmll_fifo #(
      .WIDTH(ENTRY_W)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (burst_push),
      .wr_data(burst_data),
      .pop    (q_pop),
      .rd_data(q_data),
      .status (q_status)
   );

   btmll_calc #(
      .BURST_SIZE (BURST_SIZE),
      .TRIM       (TRIM),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_calc (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_raw_mean  (rsp_raw_mean),
      .rsp_percent_q8(rsp_percent_q8)
   );

endmodule

>>> hdl/btmll_sort.sv
`timescale 1ns / 1ps
// Insertion-sorting sample chain that collects one burst and hands it on when complete.
module btmll_sort #(
   parameter int BURST_SIZE  = 9,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [SAMPLE_BITS-1:0]            sample,
   output logic                              burst_push,
   output logic [BURST_SIZE*SAMPLE_BITS-1:0] burst_data
);

   localparam int CNT_W = (BURST_SIZE > 1) ? $clog2(BURST_SIZE) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BURST_SIZE - 1);

   logic [SAMPLE_BITS-1:0] chain_ff [BURST_SIZE];
   logic [SAMPLE_BITS-1:0] chain_in [BURST_SIZE];
   logic [BURST_SIZE-1:0]  gt;
   logic [BURST_SIZE-1:0]  below;
   logic [BURST_SIZE-1:0]  at_end;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   // Each cell compares the new sample with its own entry; entries above the
   // sample move one place up and the sample drops into the gap.
   genvar i;
   generate
      for (i = 0; i < BURST_SIZE; i++) begin : g_cell
         assign below[i]  = CNT_W'(i) < count_ff;
         assign at_end[i] = CNT_W'(i) == count_ff;
         assign gt[i]     = below[i] && (chain_ff[i] > sample);
         if (i == 0) begin : g_first
            always_comb begin
               if (below[i] && !gt[i]) begin
                  chain_in[i] = chain_ff[i];
               end else if (below[i] || at_end[i]) begin
                  chain_in[i] = sample;
               end else begin
                  chain_in[i] = chain_ff[i];
               end
            end
         end else begin : g_rest
            always_comb begin
               if (below[i] && !gt[i]) begin
                  chain_in[i] = chain_ff[i];
               end else if (below[i] || at_end[i]) begin
                  chain_in[i] = gt[i-1] ? chain_ff[i-1] : sample;
               end else begin
                  chain_in[i] = chain_ff[i];
               end
            end
         end
         assign burst_data[i*SAMPLE_BITS +: SAMPLE_BITS] = chain_in[i];
      end
   endgenerate

   assign burst_push = push && (count_ff == LAST_CNT);

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = (count_ff == LAST_CNT) ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         chain_ff <= chain_in;
      end
   end

endmodule

>>> hdl/btmll_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue that holds complete sorted bursts.
module btmll_fifo #(
   parameter int WIDTH = 90
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        wr_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        rd_data,
   output btmll_pkg::q_status_type status
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign status.full  = cnt_ff == 2'd2;
   assign status.empty = cnt_ff == 2'd0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/btmll_div.sv
`timescale 1ns / 1ps
// Divider by a constant that multiplies by a scaled reciprocal and registers the quotient.
module btmll_div #(
   parameter int DW      = 25,
   parameter int DIVISOR = 1023
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   output logic          done,
   output logic [DW-1:0] quotient
);

   // With SH = DW + ceil(log2(DIVISOR)) and the reciprocal rounded up, the
   // truncated product equals the exact quotient for every DW-bit dividend.
   localparam int SH = DW + $clog2(DIVISOR);
   localparam int RW = DW + 2;
   localparam int PW = DW + RW;
   localparam logic [63:0] ONE_SH    = 64'd1 << SH;
   localparam logic [63:0] DIV_L     = 64'(DIVISOR);
   localparam logic [63:0] RECIP_VAL = (ONE_SH + DIV_L - 64'd1) / DIV_L;
   localparam logic [RW-1:0] RECIP   = RW'(RECIP_VAL);

   logic          done_ff;
   logic [DW-1:0] quot_ff;
   logic [PW-1:0] product;

   assign product  = PW'(dividend) * PW'(RECIP);
   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= DW'(product >> SH);
      end
   end

endmodule

>>> hdl/btmll_calc.sv
`timescale 1ns / 1ps
// Back end: sums the kept samples of a burst, divides, scales and holds the result.
module btmll_calc #(
   parameter int BURST_SIZE  = 9,
   parameter int TRIM        = 2,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  btmll_pkg::q_status_type           q_status,
   input  logic [BURST_SIZE*SAMPLE_BITS-1:0] q_data,
   output logic                              q_pop,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic [SAMPLE_BITS-1:0]            rsp_raw_mean,
   output logic [btmll_pkg::PCT_W-1:0]       rsp_percent_q8
);

   localparam int T_LIM  = (BURST_SIZE - 1) / 2;
   localparam int T_EFF  = (TRIM > T_LIM) ? T_LIM : TRIM;
   localparam int KEPT   = BURST_SIZE - 2 * T_EFF;
   localparam int IDX_W  = $clog2(BURST_SIZE);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(BURST_SIZE);
   localparam int DW     = SAMPLE_BITS + btmll_pkg::PCT_W;
   localparam int MAX_INT = (1 << SAMPLE_BITS) - 1;
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(T_EFF);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BURST_SIZE - 1 - T_EFF);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_DIV1  = 3'd2;
   localparam logic [2:0] S_WAIT1 = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DIV2  = 3'd5;
   localparam logic [2:0] S_WAIT2 = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]                     state_ff, state_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [SUM_W-1:0]               acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0]         mean_ff, mean_in;
   logic [DW-1:0]                  prod_ff, prod_in;
   logic [btmll_pkg::PCT_W-1:0]    pct_ff, pct_in;
   logic                           out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]         out_mean_ff, out_mean_in;
   logic [btmll_pkg::PCT_W-1:0]    out_pct_ff, out_pct_in;
   logic [SAMPLE_BITS-1:0]         entry;
   logic                           mean_start;
   logic [SUM_W-1:0]               mean_num;
   logic                           mean_done;
   logic [SUM_W-1:0]               mean_quot;
   logic                           pct_start;
   logic                           pct_done;
   logic [DW-1:0]                  pct_quot;
   logic                           out_free;

   // Rounded mean: (sum + KEPT/2) / KEPT.
   btmll_div #(
      .DW     (SUM_W),
      .DIVISOR(KEPT)
   ) u_mean_div (
      .clock   (clock),
      .reset   (reset),
      .start   (mean_start),
      .dividend(mean_num),
      .done    (mean_done),
      .quotient(mean_quot)
   );

   // Brightness scaling: divide by the full-scale ADC code.
   btmll_div #(
      .DW     (DW),
      .DIVISOR(MAX_INT)
   ) u_pct_div (
      .clock   (clock),
      .reset   (reset),
      .start   (pct_start),
      .dividend(prod_ff),
      .done    (pct_done),
      .quotient(pct_quot)
   );

   assign entry          = q_data[idx_ff*SAMPLE_BITS +: SAMPLE_BITS];
   assign mean_num       = acc_ff + SUM_W'(KEPT / 2);
   assign out_free       = !out_valid_ff || rsp_pop;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_raw_mean   = out_mean_ff;
   assign rsp_percent_q8 = out_pct_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      pct_in       = pct_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_mean_in  = out_mean_ff;
      out_pct_in   = out_pct_ff;
      q_pop        = 1'b0;
      mean_start   = 1'b0;
      pct_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               idx_in   = FIRST_IDX;
               acc_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            acc_in = acc_ff + SUM_W'(entry);
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               q_pop    = 1'b1;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            mean_start = 1'b1;
            state_in   = S_WAIT1;
         end
         S_WAIT1: begin
            if (mean_done) begin
               mean_in  = (mean_quot > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                           : mean_quot[SAMPLE_BITS-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Darkness reading turned into brightness, scaled, plus half the divisor.
            prod_in  = DW'(SAMPLE_MAX - mean_ff) * DW'(btmll_pkg::PCT_FULL_Q8)
                       + DW'(SAMPLE_MAX >> 1);
            state_in = S_DIV2;
         end
         S_DIV2: begin
            pct_start = 1'b1;
            state_in  = S_WAIT2;
         end
         S_WAIT2: begin
            if (pct_done) begin
               pct_in   = (pct_quot > DW'(btmll_pkg::PCT_FULL_Q8)) ? btmll_pkg::PCT_FULL_Q8
                                                                   : pct_quot[btmll_pkg::PCT_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_mean_in  = mean_ff;
               out_pct_in   = pct_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      prod_ff     <= prod_in;
      pct_ff      <= pct_in;
      out_mean_ff <= out_mean_in;
      out_pct_ff  <= out_pct_in;
   end

endmodule
